// File: hw/rtl/uss_pkg.sv
// Shared types and constants for the unordered set store.
// Used by the channel interfaces, the controller, the datapath and the top level.
package uss_pkg;

  localparam int ELEM_W = 32;
  localparam int OP_W   = 2;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the request, reset the walk
    logic scan;        // one step of the linear search
    logic append;      // write the value at slot count, count up
    logic shift_init;  // start the move-down after the found slot
    logic shift;       // one step of the move-down
    logic dec;         // count down
    logic out_load;    // load the result register
    logic res_ok;      // success bit of the result
    logic res_slot;    // position from the slot register, else zero
  } uss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            found;
    logic            walk_done;
    logic            out_free;
  } uss_status_t;

endpackage

// File: hw/rtl/uss_if.sv
// Valid/ready channel interfaces for requests and results of the set store.
// Depends on uss_pkg for field widths.
interface uss_req_if;
  import uss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [ELEM_W-1:0] element;
  modport source (output valid, operation, element, input ready);
  modport sink   (input valid, operation, element, output ready);
endinterface

interface uss_rsp_if;
  import uss_pkg::*;
  logic             valid;
  logic             ready;
  logic             success;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] count;
  modport source (output valid, success, position, count, input ready);
  modport sink   (input valid, success, position, count, output ready);
endinterface

// File: hw/rtl/uss_ctrl.sv
// Sequencer of the set store: check, search, append or move-down, result.
// Depends on uss_pkg; drives the datapath through uss_cmd_t.
module uss_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  uss_pkg::uss_status_t status,
  output uss_pkg::uss_cmd_t    cmd
);
  import uss_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t state, state_next;
  logic   res_ok, res_ok_next;
  logic   res_slot, res_slot_next;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_ok_next   = res_ok;
    res_slot_next = res_slot;
    req_ready     = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        res_ok_next   = 1'b0;
        res_slot_next = 1'b0;
        if ((status.op == OP_INSERT && status.full) ||
            (status.op != OP_INSERT && status.op != OP_REMOVE &&
             status.op != OP_LOOKUP)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.found || status.walk_done) begin
          res_ok_next   = status.found;
          res_slot_next = status.found;
          state_next    = S_DONE;
          if (status.op == OP_INSERT && !status.found) begin
            cmd.append    = 1'b1;   // slot register takes the old count
            res_ok_next   = 1'b1;
            res_slot_next = 1'b1;
          end else if (status.op == OP_REMOVE && status.found) begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.walk_done) begin
          cmd.dec    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.res_ok   = res_ok;
        cmd.res_slot = res_slot;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_ok   <= 1'b0;
      res_slot <= 1'b0;
    end else begin
      state    <= state_next;
      res_ok   <= res_ok_next;
      res_slot <= res_slot_next;
    end
  end

endmodule

// File: hw/rtl/uss_datapath.sv
// Element memory, count, walk pointer, capacity register and result register.
// Depends on uss_pkg and uss_if; steered by uss_ctrl.
module uss_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [uss_pkg::CAP_W-1:0]       cfg_data,
  input  logic [uss_pkg::OP_W-1:0]        req_operation,
  input  logic signed [uss_pkg::ELEM_W-1:0] req_element,
  input  uss_pkg::uss_cmd_t               cmd,
  output uss_pkg::uss_status_t            status,
  uss_rsp_if.source                       rsp
);
  import uss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic signed [ELEM_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]         capacity;
  logic [OP_W-1:0]          op_r;
  logic signed [ELEM_W-1:0] value_r;
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic                     rd_valid;
  logic [AW-1:0]            rd_tag;
  logic signed [ELEM_W-1:0] rdata;
  logic                     found;
  logic [AW-1:0]            slot;

  logic                     hit, more, issue, full;
  logic                     we;
  logic [AW-1:0]            wa;
  logic signed [ELEM_W-1:0] wd;

  assign more  = (idx < count);
  assign hit   = cmd.scan && rd_valid && (rdata == value_r);
  assign issue = (cmd.scan && more && !found && !hit) || (cmd.shift && more);
  assign full  = (LW'(count) >= LW'(capacity)) || (count >= CW'(DEPTH));

  // during the move-down, the word read last cycle lands one slot lower
  assign we = cmd.append || (cmd.shift && rd_valid);
  assign wa = cmd.append ? count[AW-1:0] : rd_tag - AW'(1);
  assign wd = cmd.append ? value_r : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req_operation;
      value_r <= req_element;
    end
    if (issue) begin
      rd_tag <= idx[AW-1:0];
    end
    if (hit) begin
      slot <= rd_tag;
    end else if (cmd.append) begin
      slot <= count[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      idx       <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      rd_valid <= issue;
      if (cmd.load) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (cmd.shift_init) begin
        idx <= CW'(slot) + CW'(1);
      end else if (issue) begin
        idx <= idx + CW'(1);
      end
      if (hit) begin
        found <= 1'b1;
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.dec) begin
        count <= count - CW'(1);
      end
      if (cmd.out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.success  <= cmd.res_ok;
      rsp.position <= cmd.res_slot ? POS_W'(slot) : '0;
      rsp.count    <= CNT_W'(count);
    end
  end

  assign status.op        = op_r;
  assign status.full      = full;
  assign status.found     = found;
  assign status.walk_done = !more && !rd_valid;
  assign status.out_free  = !rsp.valid || rsp.ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond store depth");
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !full)
    else $error("append into a full set");
  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec |-> (count != '0 && found))
    else $error("count down without a found element");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !cmd.out_load)
    else $error("result register overwritten while still waiting");
`endif

endmodule

// File: hw/rtl/unordered_set_store.sv
// Unordered set of distinct signed 32-bit values, kept packed in slots 0..count-1 of a
// DEPTH-word memory in insertion order. Each request (insert, remove, lookup) gives one
// result with success, slot and the count after the request. The memory has one read and
// one write port, so a request is a linear walk over the held elements, one word a cycle:
// a lookup or insert walks the held elements; a remove walks up to the slot, then moves the
// later entries down. An insert into a full set, or an unused operation code, goes straight
// to its result. One request is worked on at a time; the next is taken while the previous
// result still waits in the output register. No clearing pass after reset. The user must
// write capacity only while no request is in flight; the block does not enforce it.
module unordered_set_store #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [uss_pkg::CAP_W-1:0] cfg_data,
  uss_req_if.sink                   req,
  uss_rsp_if.source                 rsp
);
  import uss_pkg::*;

  uss_cmd_t    cmd;
  uss_status_t status;

  uss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  uss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .req_operation (req.operation),
    .req_element   (req.element),
    .cmd           (cmd),
    .status        (status),
    .rsp           (rsp)
  );

endmodule

// File: bench/unordered_set_store_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for unordered_set_store: a set mirror predicts every result.
// Depends on uss_pkg and the uss_req_if / uss_rsp_if channel interfaces.
module unordered_set_store_tb;
  import uss_pkg::*;

  localparam int DEPTH           = 64;
  localparam int POOL_N          = 80;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int LONG_HOLD       = 400;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_ONE_IN_FOUR, RDY_MOSTLY} stall_mode_t;

  typedef struct packed {
    logic             success;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
  } set_result_t;

  // Mirror of the set contents; predicts one result per request.
  class set_checker;
    logic [ELEM_W-1:0] held [DEPTH];
    int unsigned       held_n;
    int unsigned       capacity;
    set_result_t       awaited [$];
    int                errors;

    function new();
      held_n   = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function bit find(input logic [ELEM_W-1:0] v, output int unsigned slot);
      for (int i = 0; i < held_n; i++) begin
        if (held[i] == v) begin
          slot = i;
          return 1'b1;
        end
      end
      slot = 0;
      return 1'b0;
    endfunction

    function void apply_request(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] v);
      int unsigned lim;
      int unsigned slot;
      bit          ok;
      set_result_t r;
      lim  = (capacity < DEPTH) ? capacity : DEPTH;
      slot = 0;
      ok   = 1'b0;
      case (op)
        OP_INSERT: begin
          // a full set refuses even a value it already holds
          if (held_n < lim) begin
            ok = 1'b1;
            if (!find(v, slot)) begin
              slot         = held_n;
              held[held_n] = v;
              held_n++;
            end
          end
        end
        OP_REMOVE: begin
          if (find(v, slot)) begin
            ok = 1'b1;
            for (int i = slot; i + 1 < held_n; i++) held[i] = held[i+1];
            held_n--;
          end
        end
        OP_LOOKUP: ok = find(v, slot);
        default: ;
      endcase
      r.success  = ok;
      r.position = slot[POS_W-1:0];
      r.count    = held_n[CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(input logic s, input logic [POS_W-1:0] p,
                               input logic [CNT_W-1:0] c);
      set_result_t e;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: success %0d position %0d count %0d",
               s, p, c);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (s !== e.success) begin
        $error("success: expected %0d, got %0d", e.success, s);
        errors++;
      end
      if (p !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, p);
        errors++;
      end
      if (c !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, c);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  int               cycle_count;
  int               hold_requests;
  logic [ELEM_W-1:0] value_pool [POOL_N];
  set_checker       sb;

  uss_req_if req_ch ();
  uss_rsp_if rsp_ch ();

  unordered_set_store #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One request; returns at the edge where it is taken.
  task automatic issue(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] v);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.element   <= v;
    do @(posedge clk); while (!req_ch.ready);
    sb.apply_request(op, v);
  endtask

  task automatic pause(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.set_capacity(v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Removes and lookups mostly hit held values so the set keeps churning.
  function automatic logic [ELEM_W-1:0] pick_element(input logic [OP_W-1:0] op);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.held_n != 0 && r < ((op == OP_INSERT) ? 20 : 60))
      return sb.held[$urandom_range(0, sb.held_n - 1)];
    if (r < 80) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_INSERT;
    if (r < 70) return OP_REMOVE;
    if (r < 95) return OP_LOOKUP;
    return OP_UNUSED;
  endfunction

  // Result side: own stall pattern, plus a long hold-off on request.
  initial begin : rsp_side
    stall_mode_t mode;
    int          mode_left;
    int          hold;
    int          served;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    hold      = 0;
    served    = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.success, rsp_ch.position, rsp_ch.count);
      if (served != hold_requests) begin
        served = hold_requests;
        hold   = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS:      rsp_ch.ready <= 1'b1;
          RDY_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
          RDY_ONE_IN_FOUR: rsp_ch.ready <= (mode_left % 4 == 0);
          default:         rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : req_side
    logic [CAP_W-1:0] phase_caps [8];
    logic [OP_W-1:0]  op;
    int               burst_left;
    sb            = new();
    hold_requests = 0;
    phase_caps    = '{7'd64, 7'd17, 7'd127, 7'd1, 7'd0, 7'd40, 7'd2, 7'd127};
    for (int i = 0; i < POOL_N; i++) value_pool[i] = $urandom();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= CAP_RESET;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_INSERT;
    req_ch.element   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_capacity(7'd64);

    // directed: empty set, field extremes, duplicate, front removal, absent values
    issue(OP_LOOKUP, 32'h8000_0000);
    issue(OP_REMOVE, 32'h8000_0000);
    issue(OP_INSERT, 32'h8000_0000);
    issue(OP_INSERT, 32'h7FFF_FFFF);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'h7FFF_FFFF);
    issue(OP_LOOKUP, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 32'h0000_0001);
    issue(OP_REMOVE, 32'h8000_0000);
    issue(OP_REMOVE, 32'h0001_2345);
    issue(OP_UNUSED, 32'h5555_5555);
    issue(OP_UNUSED, 32'hAAAA_AAAA);
    // capacity lowered under the count: full set refuses even held values
    drain_results();
    write_capacity(7'd2);
    issue(OP_INSERT, 32'h0000_0007);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_LOOKUP, 32'h0000_0000);
    issue(OP_REMOVE, 32'h0000_0000);
    issue(OP_INSERT, 32'h0000_0007);
    issue(OP_REMOVE, 32'h7FFF_FFFF);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_INSERT, 32'h0000_0000);
    drain_results();
    write_capacity(7'd0);
    issue(OP_INSERT, 32'h0000_0005);
    issue(OP_REMOVE, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_capacity(phase_caps[ph]);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 20) begin
          // results held off while requests keep coming, so the input backs up
          hold_requests++;
          burst_left = 16;
        end
        if (n == 100 || $urandom_range(0, 199) == 0) drain_results();
        op = pick_op();
        issue(op, pick_element(op));
        burst_left--;
        if (burst_left == 0) begin
          pause($urandom_range(1, 15));
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
        end
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
